FILE: rtl/core/ps2dt_pkg.sv
`timescale 1ns / 1ps

package ps2dt_pkg;

    // Resend code sent after a bad host frame.
    localparam logic [7:0] RESEND_CODE = 8'hFE;

    // Register reset values.
    localparam logic [7:0]  BIT_HALF_RESET    = 8'd15;
    localparam logic [7:0]  CLOCK_LOW_RESET   = 8'd38;
    localparam logic [7:0]  ACK_RELEASE_RESET = 8'd10;
    localparam logic [7:0]  IDLE_SAMP_RESET   = 8'd5;
    localparam logic [7:0]  REQ_SAMP_RESET    = 8'd4;
    localparam logic [15:0] RETRY_DELAY_RESET = 16'd1000;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_HALF    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_RELEASE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_SAMP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQ_SAMP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_DELAY = 3'd5;

    // Current register set.
    typedef struct packed {
        logic [7:0]  bit_half_ticks;
        logic [7:0]  clock_low_ticks;
        logic [7:0]  ack_release_ticks;
        logic [7:0]  idle_samples;
        logic [7:0]  request_samples;
        logic [15:0] retry_delay_ticks;
    } t_cfg;

    // One input tick.
    typedef struct packed {
        logic [7:0] send_byte;
        logic       send_valid;
        logic       data_line;
        logic       clock_line;
    } t_tick;

    // One result item.
    typedef struct packed {
        logic       retry_queued;
        logic       tx_done;
        logic       send_ready;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       data_drive_low;
        logic       clock_drive_low;
    } t_result;

    // Link phases, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE       = 10'b00_0000_0001,
        PH_TX_SETUP   = 10'b00_0000_0010,
        PH_TX_HOLD    = 10'b00_0000_0100,
        PH_TX_LOW     = 10'b00_0000_1000,
        PH_RX_SAMPLE  = 10'b00_0001_0000,
        PH_RX_HOLD    = 10'b00_0010_0000,
        PH_RX_LOW     = 10'b00_0100_0000,
        PH_RX_ACKREL  = 10'b00_1000_0000,
        PH_RETRY_WAIT = 10'b01_0000_0000,
        PH_RETRY_QUAL = 10'b10_0000_0000
    } t_phase;

    // Line pattern being qualified.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RTS  = 2'd1,
        KIND_IDLE = 2'd2
    } t_kind;

endpackage

FILE: rtl/core/ps2_device_transceiver_unit.sv
`timescale 1ns / 1ps
// A tick item waits in the input register and its result item in the result register.
// Throughput: one tick item per cycle unless stalled; the link FSM steps once per item.
// The input register refills in the same cycle that the result register is taken.
// Reset (synchronous, active low) restores the default timing registers, idles the link,
// releases both line drives, clears the pending byte and empties both registers.

module ps2_device_transceiver_unit
    import ps2dt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] clock_line, [1] data_line, [2] send_valid, [10:3] send_byte, [15:11] zero
    input  logic [15:0]            s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] clock_drive_low, [1] data_drive_low, [2] rx_valid, [10:3] rx_byte,
    // [11] send_ready, [12] tx_done, [13] retry_queued, [15:14] zero
    output logic [15:0]            m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [15:0]            i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    logic    r_in_valid;
    t_tick   r_in_tick;
    logic    r_out_valid;
    t_result r_out_result;
    logic    advance;
    logic    step;

    assign o_cfg_ready = 1'b1;

    ps2dt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The pipe moves when the result register is empty or being taken.
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_tick <= t_tick'(s_axis_tdata[10:0]);
        end
    end

    ps2dt_link_fsm u_link_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_tick   (r_in_tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_result};

endmodule

FILE: rtl/core/ps2dt_cfg_regs.sv
`timescale 1ns / 1ps

module ps2dt_cfg_regs
    import ps2dt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_wr_index,
    input  logic [15:0]            i_wr_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    // Register file; writes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_half_ticks    <= BIT_HALF_RESET;
            r_cfg.clock_low_ticks   <= CLOCK_LOW_RESET;
            r_cfg.ack_release_ticks <= ACK_RELEASE_RESET;
            r_cfg.idle_samples      <= IDLE_SAMP_RESET;
            r_cfg.request_samples   <= REQ_SAMP_RESET;
            r_cfg.retry_delay_ticks <= RETRY_DELAY_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_BIT_HALF:    r_cfg.bit_half_ticks    <= i_wr_data[7:0];
                CFG_CLOCK_LOW:   r_cfg.clock_low_ticks   <= i_wr_data[7:0];
                CFG_ACK_RELEASE: r_cfg.ack_release_ticks <= i_wr_data[7:0];
                CFG_IDLE_SAMP:   r_cfg.idle_samples      <= i_wr_data[7:0];
                CFG_REQ_SAMP:    r_cfg.request_samples   <= i_wr_data[7:0];
                CFG_RETRY_DELAY: r_cfg.retry_delay_ticks <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/core/ps2dt_link_fsm.sv
`timescale 1ns / 1ps

module ps2dt_link_fsm
    import ps2dt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_tick   i_tick,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_tick, n_tick;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic        r_bad, n_bad;
    logic [7:0]  r_qcnt, n_qcnt;
    t_kind       r_qkind, n_qkind;
    logic        r_pend_valid, n_pend_valid;
    logic [7:0]  r_pend_byte, n_pend_byte;
    logic [7:0]  r_rx_byte, n_rx_byte;
    logic        r_drv_clk, n_drv_clk;
    logic        r_drv_data, n_drv_data;

    logic        rts, idle;
    logic [15:0] tick_inc, limit;
    logic        t_done;
    logic [3:0]  bit_m1;
    logic        tx_bit;
    t_kind       q_kind;
    logic [7:0]  q_base, q_cnt_n, q_thr;
    logic        q_hit;
    logic        rx_valid, tx_done, retry_queued;

    assign rts  = i_tick.clock_line && !i_tick.data_line;
    assign idle = i_tick.clock_line && i_tick.data_line;

    // Shared tick timer: the limit depends on the phase.
    always_comb begin
        tick_inc = r_tick + 16'd1;
        unique case (r_phase)
            PH_TX_SETUP, PH_TX_HOLD, PH_RX_SAMPLE, PH_RX_HOLD:
                limit = {8'd0, i_cfg.bit_half_ticks};
            PH_TX_LOW, PH_RX_LOW:
                limit = {8'd0, i_cfg.clock_low_ticks};
            PH_RX_ACKREL:
                limit = {8'd0, i_cfg.ack_release_ticks};
            PH_RETRY_WAIT:
                limit = i_cfg.retry_delay_ticks;
            default:
                limit = 16'hFFFF;
        endcase
        t_done = (tick_inc >= limit);
    end

    // Frame bit to send for the current bit position.
    always_comb begin
        bit_m1 = r_bit - 4'd1;
        if (r_bit == 4'd0) begin
            tx_bit = 1'b0;
        end else if (r_bit <= 4'd8) begin
            tx_bit = r_shift[bit_m1[2:0]];
        end else if (r_bit == 4'd9) begin
            tx_bit = ~(^r_shift);
        end else begin
            tx_bit = 1'b1;
        end
    end

    // Line pattern qualifier with a saturating sample count.
    // A byte offered on this tick already counts as pending.
    always_comb begin
        q_kind = KIND_NONE;
        if (r_phase == PH_IDLE) begin
            if (rts) begin
                q_kind = KIND_RTS;
            end else if (idle && (r_pend_valid || i_tick.send_valid)) begin
                q_kind = KIND_IDLE;
            end
        end else if (r_phase == PH_RETRY_QUAL) begin
            if (idle) begin
                q_kind = KIND_IDLE;
            end
        end
        q_base  = (q_kind != r_qkind) ? 8'd0 : r_qcnt;
        q_cnt_n = (q_base != 8'hFF) ? q_base + 8'd1 : q_base;
        q_thr   = (q_kind == KIND_RTS) ? i_cfg.request_samples : i_cfg.idle_samples;
        q_hit   = (q_cnt_n >= q_thr);
    end

    // Next state for one tick.
    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_bad        = r_bad;
        n_qcnt       = r_qcnt;
        n_qkind      = r_qkind;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_rx_byte    = r_rx_byte;
        n_drv_clk    = r_drv_clk;
        n_drv_data   = r_drv_data;
        rx_valid     = 1'b0;
        tx_done      = 1'b0;
        retry_queued = 1'b0;

        // An offered byte is taken whenever nothing is pending.
        if (i_tick.send_valid && !r_pend_valid) begin
            n_pend_valid = 1'b1;
            n_pend_byte  = i_tick.send_byte;
        end

        unique case (r_phase)
            PH_IDLE, PH_RETRY_QUAL: begin
                if (q_kind != KIND_NONE) begin
                    n_qcnt  = q_cnt_n;
                    n_qkind = q_kind;
                    if (q_hit) begin
                        n_tick  = 16'd0;
                        n_bit   = 4'd0;
                        n_qcnt  = 8'd0;
                        n_qkind = KIND_NONE;
                        if (r_phase == PH_RETRY_QUAL) begin
                            n_phase = PH_TX_SETUP;
                            n_shift = RESEND_CODE;
                            n_bad   = 1'b1;
                        end else if (q_kind == KIND_RTS) begin
                            n_phase = PH_RX_SAMPLE;
                            n_shift = 8'd0;
                            n_bad   = 1'b0;
                        end else begin
                            n_phase = PH_TX_SETUP;
                            n_shift = n_pend_byte;
                            n_bad   = 1'b0;
                        end
                    end
                end else begin
                    n_qcnt  = 8'd0;
                    n_qkind = KIND_NONE;
                end
            end
            PH_TX_SETUP: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_data = ~tx_bit;
                    n_phase    = PH_TX_HOLD;
                end
            end
            PH_TX_HOLD: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_clk = 1'b1;
                    n_phase   = PH_TX_LOW;
                end
            end
            PH_TX_LOW: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_clk = 1'b0;
                    if (r_bit >= 4'd10) begin
                        n_drv_data = 1'b0;
                        if (!r_bad) begin
                            tx_done      = 1'b1;
                            n_pend_valid = 1'b0;
                        end
                        n_phase = PH_IDLE;
                        n_bit   = 4'd0;
                        n_qcnt  = 8'd0;
                        n_qkind = KIND_NONE;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_TX_SETUP;
                    end
                end
            end
            PH_RX_SAMPLE: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    if (r_bit == 4'd0) begin
                        if (i_tick.data_line) begin
                            n_bad = 1'b1;
                        end
                    end else if (r_bit <= 4'd8) begin
                        n_shift[bit_m1[2:0]] = r_shift[bit_m1[2:0]] | i_tick.data_line;
                    end else if (r_bit == 4'd9) begin
                        // Odd parity over data and parity bit.
                        if (!((^r_shift) ^ i_tick.data_line)) begin
                            n_bad = 1'b1;
                        end
                    end
                    n_phase = PH_RX_HOLD;
                end
            end
            PH_RX_HOLD: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_clk = 1'b1;
                    if (r_bit >= 4'd10) begin
                        n_drv_data = 1'b1;
                    end
                    n_phase = PH_RX_LOW;
                end
            end
            PH_RX_LOW: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_clk = 1'b0;
                    if (r_bit >= 4'd10) begin
                        n_phase = PH_RX_ACKREL;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_RX_SAMPLE;
                    end
                end
            end
            PH_RX_ACKREL: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_drv_data = 1'b0;
                    n_bit      = 4'd0;
                    if (r_bad) begin
                        retry_queued = 1'b1;
                        n_phase      = PH_RETRY_WAIT;
                    end else begin
                        rx_valid  = 1'b1;
                        n_rx_byte = r_shift;
                        n_phase   = PH_IDLE;
                    end
                    n_qcnt  = 8'd0;
                    n_qkind = KIND_NONE;
                end
            end
            PH_RETRY_WAIT: begin
                n_tick = t_done ? 16'd0 : tick_inc;
                if (t_done) begin
                    n_phase = PH_RETRY_QUAL;
                    n_qcnt  = 8'd0;
                    n_qkind = KIND_NONE;
                end
            end
            default: begin
                n_phase    = PH_IDLE;
                n_tick     = 16'd0;
                n_bit      = 4'd0;
                n_drv_clk  = 1'b0;
                n_drv_data = 1'b0;
                n_qcnt     = 8'd0;
                n_qkind    = KIND_NONE;
            end
        endcase
    end

    // State advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= 16'd0;
            r_bit        <= 4'd0;
            r_shift      <= 8'd0;
            r_bad        <= 1'b0;
            r_qcnt       <= 8'd0;
            r_qkind      <= KIND_NONE;
            r_pend_valid <= 1'b0;
            r_pend_byte  <= 8'd0;
            r_rx_byte    <= 8'd0;
            r_drv_clk    <= 1'b0;
            r_drv_data   <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_bad        <= n_bad;
            r_qcnt       <= n_qcnt;
            r_qkind      <= n_qkind;
            r_pend_valid <= n_pend_valid;
            r_pend_byte  <= n_pend_byte;
            r_rx_byte    <= n_rx_byte;
            r_drv_clk    <= n_drv_clk;
            r_drv_data   <= n_drv_data;
        end
    end

    // Result of this tick.
    always_comb begin
        o_result.clock_drive_low = n_drv_clk;
        o_result.data_drive_low  = n_drv_data;
        o_result.rx_valid        = rx_valid;
        o_result.rx_byte         = n_rx_byte;
        o_result.send_ready      = ~n_pend_valid;
        o_result.tx_done         = tx_done;
        o_result.retry_queued    = retry_queued;
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ps2dt_pkg::*;

    // Longest receiver hold-off and the quiet-cycle limit of the watchdog.
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 3000;
    // Upper bound on ticks spent waiting for the link to reach a given state.
    localparam int LINK_GUARD  = 2000;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RDY_ALWAYS  = 2'd0,
        RDY_RANDOM  = 2'd1,
        RDY_PATTERN = 2'd2
    } t_rdy_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [15:0]            s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [15:0]            i_cfg_data = '0;

    ps2_device_transceiver_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the link state and the timing registers.
    t_cfg        cfg;
    t_phase      ph;
    logic [15:0] tick_cnt;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic        frame_bad;
    logic [7:0]  qual_cnt;
    t_kind       qual_kind;
    logic        pend_v;
    logic [7:0]  pend_b;
    logic [7:0]  rx_b;
    logic        drv_clk;
    logic        drv_dat;

    // Line outputs expected for ticks that are accepted but not yet seen.
    t_result link_out_q[$];

    int errors = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int rx_good_cnt = 0;
    int tx_done_cnt = 0;
    int retry_cnt = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    logic      hold_start = 1'b0;
    int        hold_left = 0;
    int        mode_left = 0;
    int        pattern_pos = 0;
    t_rdy_mode rdy_mode = RDY_ALWAYS;

    // Link timers and line qualifiers, stepping the shadow state.
    function automatic logic timer_hit(input logic [15:0] limit);
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= limit) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_qualifier();
        qual_cnt  = '0;
        qual_kind = KIND_NONE;
    endfunction

    function automatic logic qualify_hit(input t_kind kind, input logic [7:0] threshold);
        if (kind != qual_kind) qual_cnt = '0;
        qual_kind = kind;
        if (qual_cnt < 8'd255) qual_cnt = qual_cnt + 8'd1;
        return qual_cnt >= threshold;
    endfunction

    function automatic void start_link_frame(input t_phase nxt, input logic [7:0] val,
                                             input logic bad);
        ph        = nxt;
        tick_cnt  = '0;
        bit_idx   = '0;
        shreg     = val;
        frame_bad = bad;
        clear_qualifier();
    endfunction

    function automatic logic link_in_rx();
        return ph == PH_RX_SAMPLE || ph == PH_RX_HOLD || ph == PH_RX_LOW ||
               ph == PH_RX_ACKREL;
    endfunction

    // Advances the shadow link by one tick and returns the line outputs it should show.
    function automatic t_result link_tick(input t_tick t);
        t_result r;
        logic    rts;
        logic    idl;
        r   = '0;
        rts = t.clock_line && !t.data_line;
        idl = t.clock_line && t.data_line;
        if (t.send_valid && !pend_v) begin
            pend_v = 1'b1;
            pend_b = t.send_byte;
        end
        case (ph)
            PH_IDLE: begin
                if (rts) begin
                    if (qualify_hit(KIND_RTS, cfg.request_samples))
                        start_link_frame(PH_RX_SAMPLE, 8'h00, 1'b0);
                end else if (idl && pend_v) begin
                    if (qualify_hit(KIND_IDLE, cfg.idle_samples))
                        start_link_frame(PH_TX_SETUP, pend_b, 1'b0);
                end else begin
                    clear_qualifier();
                end
            end
            PH_TX_SETUP: begin
                if (timer_hit({8'd0, cfg.bit_half_ticks})) begin
                    // Start bit low, data bits LSB first, odd parity, stop bit high.
                    if (bit_idx == 4'd0)      drv_dat = 1'b1;
                    else if (bit_idx <= 4'd8) drv_dat = ~shreg[3'(bit_idx - 4'd1)];
                    else if (bit_idx == 4'd9) drv_dat = ^shreg;
                    else                      drv_dat = 1'b0;
                    ph = PH_TX_HOLD;
                end
            end
            PH_TX_HOLD: begin
                if (timer_hit({8'd0, cfg.bit_half_ticks})) begin
                    drv_clk = 1'b1;
                    ph      = PH_TX_LOW;
                end
            end
            PH_TX_LOW: begin
                if (timer_hit({8'd0, cfg.clock_low_ticks})) begin
                    drv_clk = 1'b0;
                    if (bit_idx >= 4'd10) begin
                        drv_dat = 1'b0;
                        if (!frame_bad) begin
                            r.tx_done = 1'b1;
                            pend_v    = 1'b0;
                        end
                        ph      = PH_IDLE;
                        bit_idx = '0;
                        clear_qualifier();
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        ph      = PH_TX_SETUP;
                    end
                end
            end
            PH_RX_SAMPLE: begin
                if (timer_hit({8'd0, cfg.bit_half_ticks})) begin
                    if (bit_idx == 4'd0) begin
                        if (t.data_line) frame_bad = 1'b1;
                    end else if (bit_idx <= 4'd8) begin
                        shreg[3'(bit_idx - 4'd1)] = shreg[3'(bit_idx - 4'd1)] | t.data_line;
                    end else if (bit_idx == 4'd9) begin
                        if (!(^shreg ^ t.data_line)) frame_bad = 1'b1;
                    end
                    ph = PH_RX_HOLD;
                end
            end
            PH_RX_HOLD: begin
                if (timer_hit({8'd0, cfg.bit_half_ticks})) begin
                    drv_clk = 1'b1;
                    // The acknowledge pulse pulls data low with the clock.
                    if (bit_idx >= 4'd10) drv_dat = 1'b1;
                    ph = PH_RX_LOW;
                end
            end
            PH_RX_LOW: begin
                if (timer_hit({8'd0, cfg.clock_low_ticks})) begin
                    drv_clk = 1'b0;
                    if (bit_idx >= 4'd10) begin
                        ph = PH_RX_ACKREL;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        ph      = PH_RX_SAMPLE;
                    end
                end
            end
            PH_RX_ACKREL: begin
                if (timer_hit({8'd0, cfg.ack_release_ticks})) begin
                    drv_dat = 1'b0;
                    bit_idx = '0;
                    if (frame_bad) begin
                        r.retry_queued = 1'b1;
                        ph             = PH_RETRY_WAIT;
                    end else begin
                        r.rx_valid = 1'b1;
                        rx_b       = shreg;
                        ph         = PH_IDLE;
                    end
                    clear_qualifier();
                end
            end
            PH_RETRY_WAIT: begin
                if (timer_hit(cfg.retry_delay_ticks)) begin
                    ph = PH_RETRY_QUAL;
                    clear_qualifier();
                end
            end
            PH_RETRY_QUAL: begin
                if (idl) begin
                    if (qualify_hit(KIND_IDLE, cfg.idle_samples))
                        start_link_frame(PH_TX_SETUP, RESEND_CODE, 1'b1);
                end else begin
                    clear_qualifier();
                end
            end
            default: begin
                ph       = PH_IDLE;
                tick_cnt = '0;
                bit_idx  = '0;
                drv_clk  = 1'b0;
                drv_dat  = 1'b0;
                clear_qualifier();
            end
        endcase
        r.clock_drive_low = drv_clk;
        r.data_drive_low  = drv_dat;
        r.rx_byte         = rx_b;
        r.send_ready      = !pend_v;
        return r;
    endfunction

    // Offers one tick item in bursts with random gaps and records what it should produce.
    task automatic send_tick(input logic clk_l, input logic dat_l, input logic offer,
                             input logic [7:0] byte_v);
        t_tick t;
        int    gap;
        t.clock_line = clk_l;
        t.data_line  = dat_l;
        t.send_valid = offer;
        t.send_byte  = byte_v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, t};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        ticks_sent++;
        link_out_q.push_back(link_tick(t));
    endtask

    // Stops offering and waits until every expected item has come back.
    task automatic drain_link();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (link_out_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all six timing registers once no tick items are left in flight.
    task automatic set_timing(input logic [7:0] half, input logic [7:0] low,
                              input logic [7:0] ack, input logic [7:0] idle_n,
                              input logic [7:0] req_n, input logic [15:0] retry);
        logic [CFG_INDEX_W-1:0] idx [6];
        logic [15:0]            val [6];
        idx = '{CFG_BIT_HALF, CFG_CLOCK_LOW, CFG_ACK_RELEASE, CFG_IDLE_SAMP,
                CFG_REQ_SAMP, CFG_RETRY_DELAY};
        val = '{{8'd0, half}, {8'd0, low}, {8'd0, ack}, {8'd0, idle_n},
                {8'd0, req_n}, retry};
        drain_link();
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_BIT_HALF:    cfg.bit_half_ticks    = val[k][7:0];
                CFG_CLOCK_LOW:   cfg.clock_low_ticks   = val[k][7:0];
                CFG_ACK_RELEASE: cfg.ack_release_ticks = val[k][7:0];
                CFG_IDLE_SAMP:   cfg.idle_samples      = val[k][7:0];
                CFG_REQ_SAMP:    cfg.request_samples   = val[k][7:0];
                default:         cfg.retry_delay_ticks = val[k];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Keeps the bus idle until the link is back in its idle phase.
    task automatic wait_link_idle();
        int guard;
        guard = 0;
        while (ph != PH_IDLE && guard < LINK_GUARD) begin
            send_tick(1'b1, 1'b1, $urandom_range(0, 7) == 0, 8'($urandom));
            guard++;
        end
    endtask

    // Host request-to-send followed by one 11-bit host frame; the line follows the device
    // clock unless noisy; when noisy, data is only exact where the device samples it.
    task automatic host_frame(input logic [7:0] frame_byte, input logic bad_start,
                              input logic bad_parity, input logic noisy);
        int   guard;
        logic dat_l;
        logic clk_l;
        guard = 0;
        while (!link_in_rx() && guard < LINK_GUARD) begin
            send_tick(1'b1, ph != PH_IDLE, noisy && $urandom_range(0, 3) == 0,
                      8'($urandom));
            guard++;
        end
        while (link_in_rx() && guard < LINK_GUARD) begin
            if (ph == PH_RX_SAMPLE || !noisy) begin
                if (bit_idx == 4'd0)      dat_l = bad_start;
                else if (bit_idx <= 4'd8) dat_l = frame_byte[3'(bit_idx - 4'd1)];
                else if (bit_idx == 4'd9) dat_l = ~^frame_byte ^ bad_parity;
                else                      dat_l = ($urandom_range(0, 3) != 0);
            end else begin
                dat_l = 1'($urandom_range(0, 1));
            end
            clk_l = noisy ? 1'($urandom_range(0, 1)) : !drv_clk;
            send_tick(clk_l, dat_l, $urandom_range(0, 7) == 0, 8'($urandom));
            guard++;
        end
    endtask

    // Sends one byte from the device side once any earlier byte has gone out.
    task automatic device_send(input logic [7:0] val);
        int guard;
        guard = 0;
        wait_link_idle();
        while ((pend_v || ph != PH_IDLE) && guard < LINK_GUARD) begin
            send_tick(1'b1, 1'b1, 1'b0, 8'h00);
            guard++;
        end
        send_tick(1'b1, 1'b1, 1'b1, val);
        while (pend_v && guard < LINK_GUARD) begin
            send_tick(1'b1, 1'b1, $urandom_range(0, 9) == 0, 8'($urandom));
            guard++;
        end
    endtask

    task automatic line_noise(input int n);
        repeat (n) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    // Random mix of host frames, device frames and line noise.
    task automatic mixed_traffic(input int n);
        int stop_at;
        int pick;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                host_frame(8'($urandom), $urandom_range(0, 6) == 0,
                           $urandom_range(0, 5) == 0, $urandom_range(0, 1) == 1);
            else if (pick < 7)
                device_send(8'($urandom));
            else
                line_noise($urandom_range(1, 30));
        end
    endtask

    // Reset timing: idle bus with nothing to send, then the first bit of a device
    // frame at the default bit timing.
    task automatic test_default_timing();
        repeat (12) send_tick(1'b1, 1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b1, 1'b1, 8'h1C);
        repeat (80) send_tick(1'b1, 1'b1, 1'b0, 8'h00);
    endtask

    // Shortest timing: a pending byte that survives a resend frame, bad parity and
    // a bad start bit.
    task automatic test_directed_frames();
        set_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'd1);
        wait_link_idle();
        send_tick(1'b0, 1'b0, 1'b1, 8'h7E);
        host_frame(8'hA5, 1'b0, 1'b1, 1'b0);
        device_send(8'h80);
        host_frame(8'hFF, 1'b1, 1'b0, 1'b0);
        wait_link_idle();
    endtask

    // A request beats a pending byte, and changing patterns restart the sample count.
    task automatic test_request_vs_send();
        set_timing(8'd1, 8'd2, 8'd1, 8'd3, 8'd3, 16'd2);
        wait_link_idle();
        send_tick(1'b1, 1'b1, 1'b1, 8'h96);
        send_tick(1'b1, 1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b1, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, 1'b0, 8'h00);
        send_tick(1'b0, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 1'b0, 8'h00);
        send_tick(1'b1, 1'b1, 1'b0, 8'h00);
        send_tick(1'b1, 1'b0, 1'b0, 8'h00);
        host_frame(8'h69, 1'b0, 1'b0, 1'b0);
        wait_link_idle();
    endtask

    // Zero in every register acts as one tick or one sample.
    task automatic test_zero_registers();
        set_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        host_frame(8'h3A, 1'b0, 1'b0, 1'b0);
        host_frame(8'hC5, 1'b0, 1'b1, 1'b1);
        device_send(8'h55);
        line_noise(10);
        wait_link_idle();
    endtask

    // The receiver holds off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        set_timing(8'd2, 8'd1, 8'd2, 8'd2, 8'd2, 16'd10);
        hold_start = 1'b1;
        mixed_traffic(40);
        wait_link_idle();
    endtask

    // Random short timing settings with mixed traffic.
    task automatic test_random_traffic();
        repeat (2) begin
            set_timing(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)),
                       8'($urandom_range(1, 2)), 8'($urandom_range(1, 4)),
                       8'($urandom_range(1, 4)), 16'($urandom_range(1, 20)));
            mixed_traffic(20);
            wait_link_idle();
        end
    endtask

    // Largest register values: request and idle counts stay below their thresholds.
    task automatic test_slowest_timing();
        set_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        send_tick(1'b0, 1'b1, 1'b1, 8'hE0);
        repeat (40) send_tick(1'b1, 1'b0, 1'b0, 8'h00);
        repeat (20) send_tick(1'b1, 1'b1, 1'b0, 8'h00);
    endtask

    // Receiver stalls: a long hold-off on request, otherwise a changing pattern.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rdy_mode  = t_rdy_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 300);
        end else begin
            mode_left--;
        end
        pattern_pos = (pattern_pos == 6) ? 0 : pattern_pos + 1;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS: m_axis_tready <= 1'b1;
                RDY_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default:    m_axis_tready <= (pattern_pos > 1);
            endcase
        end
    end

    function automatic void cmp_field(input string name, input int unsigned want,
                                      input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compares each result item with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[13:0]);
            if (link_out_q.size() == 0) begin
                $error("result item 0x%0h arrived with nothing expected", m_axis_tdata);
                errors++;
            end else begin
                want = link_out_q.pop_front();
                results_seen++;
                cmp_field("clock_drive_low", 32'(want.clock_drive_low),
                          32'(got.clock_drive_low));
                cmp_field("data_drive_low", 32'(want.data_drive_low),
                          32'(got.data_drive_low));
                cmp_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
                cmp_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
                cmp_field("send_ready", 32'(want.send_ready), 32'(got.send_ready));
                cmp_field("tx_done", 32'(want.tx_done), 32'(got.tx_done));
                cmp_field("retry_queued", 32'(want.retry_queued), 32'(got.retry_queued));
                if (want.rx_valid) rx_good_cnt++;
                if (want.tx_done) tx_done_cnt++;
                if (want.retry_queued) retry_cnt++;
            end
        end
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg.bit_half_ticks    = BIT_HALF_RESET;
        cfg.clock_low_ticks   = CLOCK_LOW_RESET;
        cfg.ack_release_ticks = ACK_RELEASE_RESET;
        cfg.idle_samples      = IDLE_SAMP_RESET;
        cfg.request_samples   = REQ_SAMP_RESET;
        cfg.retry_delay_ticks = RETRY_DELAY_RESET;
        ph        = PH_IDLE;
        tick_cnt  = '0;
        bit_idx   = '0;
        shreg     = '0;
        frame_bad = 1'b0;
        qual_cnt  = '0;
        qual_kind = KIND_NONE;
        pend_v    = 1'b0;
        pend_b    = '0;
        rx_b      = '0;
        drv_clk   = 1'b0;
        drv_dat   = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_directed_frames();
        test_request_vs_send();
        test_zero_registers();
        test_backpressure();
        test_random_traffic();
        test_slowest_timing();

        drain_link();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d link ticks: %0d host bytes, %0d device frames, %0d resends.",
                 ticks_sent, rx_good_cnt, tx_done_cnt, retry_cnt);
        $display("Timing sets: reset, shortest, zero, random, longest; %0d items checked.",
                 results_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
